// File: src/dtpr_pkg.sv
// ----------------------------------------------------------------------------
// dtpr_pkg
// Shared types, register indexes and reset values for the disparity to point
// reprojection block.
// ----------------------------------------------------------------------------
package dtpr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FIELD_BITS     = 12;
	localparam int DISP_BITS      = 16;
	localparam int CFG_BITS       = 32;
	localparam int IDX_BITS       = 3;
	localparam int DIV_STEPS      = CFG_BITS + 4;
	localparam int DEPTH_BITS     = DIV_STEPS + 1;

	localparam logic [IDX_BITS-1:0] REG_DEPTH_SCALE = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_INV_R0C0    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_INV_R0C1    = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_INV_R0C2    = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_INV_R1C0    = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_INV_R1C1    = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_INV_R1C2    = 3'd6;

	localparam logic [CFG_BITS-1:0] RST_DEPTH_SCALE = 32'd0;
	localparam logic [CFG_BITS-1:0] RST_INV_R0C0    = 32'd23252;
	localparam logic [CFG_BITS-1:0] RST_INV_R0C1    = 32'd0;
	localparam logic [CFG_BITS-1:0] RST_INV_R0C2    = 32'hFF27_CDC9;
	localparam logic [CFG_BITS-1:0] RST_INV_R1C0    = 32'd0;
	localparam logic [CFG_BITS-1:0] RST_INV_R1C1    = 32'd23252;
	localparam logic [CFG_BITS-1:0] RST_INV_R1C2    = 32'hFFC2_AB18;

	typedef struct packed {
		logic [FIELD_BITS-1:0] pixel_column;
		logic [FIELD_BITS-1:0] pixel_row;
		logic [DISP_BITS-1:0]  disparity_q4;
	} req_t;

	typedef struct packed {
		logic                       point_valid;
		logic [15:0]                depth_word;
		logic signed [CFG_BITS-1:0] point_x;
		logic signed [CFG_BITS-1:0] point_y;
		logic [CFG_BITS-1:0]        point_z;
	} res_t;

	typedef struct packed {
		logic                 vld;
		logic                 nz;
		logic [DIV_STEPS-1:0] num;
		logic [DISP_BITS-1:0] rem;
		logic [DISP_BITS-1:0] den;
	} div_t;

endpackage

// File: src/dtpr_div_cell.sv
// ----------------------------------------------------------------------------
// dtpr_div_cell
// One restoring division step; passes the request and coordinates onward.
// ----------------------------------------------------------------------------
module dtpr_div_cell #(
	parameter int CW = dtpr_pkg::FIELD_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dtpr_pkg::div_t   din,
	input  logic [2*CW-1:0]  crd_in,
	output dtpr_pkg::div_t   dout,
	output logic [2*CW-1:0]  crd_out
);

	logic [dtpr_pkg::DISP_BITS:0]   trial;
	logic                           ge;
	logic [dtpr_pkg::DISP_BITS-1:0] rem_n;
	logic [dtpr_pkg::DISP_BITS:0]   diff;

	logic                           vld_q;
	logic                           nz_q;
	logic [dtpr_pkg::DIV_STEPS-1:0] num_q;
	logic [dtpr_pkg::DISP_BITS-1:0] rem_q;
	logic [dtpr_pkg::DISP_BITS-1:0] den_q;

	always_comb begin
		trial = {din.rem, din.num[dtpr_pkg::DIV_STEPS-1]};
		ge    = trial >= {1'b0, din.den};
		diff  = trial - {1'b0, din.den};
		rem_n = ge ? diff[dtpr_pkg::DISP_BITS-1:0] : trial[dtpr_pkg::DISP_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		nz_q    <= din.nz;
		num_q   <= {din.num[dtpr_pkg::DIV_STEPS-2:0], ge};
		rem_q   <= rem_n;
		den_q   <= din.den;
		crd_out <= crd_in;
	end

	always_comb begin
		dout.vld = vld_q;
		dout.nz  = nz_q;
		dout.num = num_q;
		dout.rem = rem_q;
		dout.den = den_q;
	end

endmodule

// File: src/dtpr_post.sv
// ----------------------------------------------------------------------------
// dtpr_post
// Rounds the quotient, forms the ray from the inverse matrix and scales it.
// ----------------------------------------------------------------------------
module dtpr_post #(
	parameter int CW = dtpr_pkg::FIELD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtpr_pkg::div_t                din,
	input  logic [2*CW-1:0]               crd,
	input  logic [dtpr_pkg::CFG_BITS-1:0] c00,
	input  logic [dtpr_pkg::CFG_BITS-1:0] c01,
	input  logic [dtpr_pkg::CFG_BITS-1:0] c02,
	input  logic [dtpr_pkg::CFG_BITS-1:0] c10,
	input  logic [dtpr_pkg::CFG_BITS-1:0] c11,
	input  logic [dtpr_pkg::CFG_BITS-1:0] c12,
	output logic                          done,
	output dtpr_pkg::res_t                res
);

	localparam int DB = dtpr_pkg::DEPTH_BITS;
	localparam int QB = dtpr_pkg::DIV_STEPS;
	localparam int PB = CW + 33;
	localparam int VW = CW + 35;
	localparam int HW = VW - 24;
	localparam int PW = VW + DB;
	localparam int RW = PW - 24;

	// stage 1: depth rounding and coordinate products
	logic                  vld_s1, nz_s1;
	logic [DB-1:0]         depth_s1;
	logic [15:0]           word_s1;
	logic signed [PB-1:0]  p00_s1, p01_s1, p10_s1, p11_s1;

	logic [QB:0]                     wsum;
	logic                            rnd;
	logic signed [CW:0]              col_x, row_x;

	always_comb begin
		wsum  = {1'b0, din.num} + (QB+1)'(32768);
		rnd   = {din.rem, 1'b0} >= {1'b0, din.den};
		col_x = $signed({1'b0, crd[2*CW-1:CW]});
		row_x = $signed({1'b0, crd[CW-1:0]});
	end

	always_ff @(posedge clk) begin
		nz_s1    <= din.nz;
		depth_s1 <= {1'b0, din.num} + DB'(rnd);
		word_s1  <= (|wsum[QB:32]) ? 16'hFFFF : wsum[31:16];
		p00_s1   <= $signed(c00) * col_x;
		p01_s1   <= $signed(c01) * row_x;
		p10_s1   <= $signed(c10) * col_x;
		p11_s1   <= $signed(c11) * row_x;
	end

	// stage 2: ray components, sign and magnitude
	logic                  vld_s2, nz_s2, n0_s2, n1_s2;
	logic [DB-1:0]         depth_s2;
	logic [15:0]           word_s2;
	logic [VW-1:0]         m0_s2, m1_s2;
	logic signed [VW-1:0]  v0, v1;

	always_comb begin
		v0 = VW'(p00_s1) + VW'(p01_s1) + VW'($signed(c02));
		v1 = VW'(p10_s1) + VW'(p11_s1) + VW'($signed(c12));
	end

	always_ff @(posedge clk) begin
		nz_s2    <= nz_s1;
		depth_s2 <= depth_s1;
		word_s2  <= word_s1;
		n0_s2    <= v0[VW-1];
		n1_s2    <= v1[VW-1];
		m0_s2    <= v0[VW-1] ? VW'(-v0) : VW'(v0);
		m1_s2    <= v1[VW-1] ? VW'(-v1) : VW'(v1);
	end

	// stage 3: partial products
	logic                vld_s3, nz_s3, n0_s3, n1_s3;
	logic [DB-1:0]       depth_s3;
	logic [15:0]         word_s3;
	logic [42:0]         ll0_s3, ll1_s3;
	logic [41:0]         lh0_s3, lh1_s3;
	logic [HW+18:0]      hl0_s3, hl1_s3;
	logic [HW+17:0]      hh0_s3, hh1_s3;

	always_ff @(posedge clk) begin
		nz_s3    <= nz_s2;
		depth_s3 <= depth_s2;
		word_s3  <= word_s2;
		n0_s3    <= n0_s2;
		n1_s3    <= n1_s2;
		ll0_s3   <= m0_s2[23:0] * depth_s2[18:0];
		lh0_s3   <= m0_s2[23:0] * depth_s2[DB-1:19];
		hl0_s3   <= m0_s2[VW-1:24] * depth_s2[18:0];
		hh0_s3   <= m0_s2[VW-1:24] * depth_s2[DB-1:19];
		ll1_s3   <= m1_s2[23:0] * depth_s2[18:0];
		lh1_s3   <= m1_s2[23:0] * depth_s2[DB-1:19];
		hl1_s3   <= m1_s2[VW-1:24] * depth_s2[18:0];
		hh1_s3   <= m1_s2[VW-1:24] * depth_s2[DB-1:19];
	end

	// stage 4: full products
	logic             vld_s4, nz_s4, n0_s4, n1_s4;
	logic [DB-1:0]    depth_s4;
	logic [15:0]      word_s4;
	logic [PW-1:0]    pr0_s4, pr1_s4;

	always_ff @(posedge clk) begin
		nz_s4    <= nz_s3;
		depth_s4 <= depth_s3;
		word_s4  <= word_s3;
		n0_s4    <= n0_s3;
		n1_s4    <= n1_s3;
		pr0_s4   <= PW'(ll0_s3) + (PW'(lh0_s3) << 19) + (PW'(hl0_s3) << 24)
			+ (PW'(hh0_s3) << 43);
		pr1_s4   <= PW'(ll1_s3) + (PW'(lh1_s3) << 19) + (PW'(hl1_s3) << 24)
			+ (PW'(hh1_s3) << 43);
	end

	// stage 5: round, saturate, output register
	logic [PW-1:0] r0, r1;
	logic [RW-1:0] q0, q1;
	logic [31:0]   x_n, y_n, z_n;

	function automatic logic [31:0] sat_coord(input logic neg, input logic [RW-1:0] q);
		logic [31:0] r;
		if (!neg) begin
			r = (|q[RW-1:31]) ? 32'h7FFF_FFFF : q[31:0];
		end else if ((|q[RW-1:32]) || (q[31] && (|q[30:0]))) begin
			r = 32'h8000_0000;
		end else begin
			r = ~q[31:0] + 32'd1;
		end
		return r;
	endfunction

	always_comb begin
		r0  = pr0_s4 + PW'(24'h80_0000);
		r1  = pr1_s4 + PW'(24'h80_0000);
		q0  = r0[PW-1:24];
		q1  = r1[PW-1:24];
		x_n = sat_coord(n0_s4, q0);
		y_n = sat_coord(n1_s4, q1);
		z_n = (|depth_s4[DB-1:32]) ? 32'hFFFF_FFFF : depth_s4[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done   <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		res.point_valid <= nz_s4;
		res.depth_word  <= nz_s4 ? word_s4 : 16'd0;
		res.point_x     <= nz_s4 ? $signed(x_n) : 32'sd0;
		res.point_y     <= nz_s4 ? $signed(y_n) : 32'sd0;
		res.point_z     <= nz_s4 ? z_n : 32'd0;
	end

endmodule

// File: src/disparity_to_point_reprojection.sv
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// Stereo disparity to depth word and 3D point, one pixel per clock.
// Pipeline: 36 divider cells, then 5 post registers; the first cell loads at the
// edge that takes start, and done comes from the last post register.
// Throughput: one request per cycle; busy is always low, tied off in this module.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset clears the pipeline valids and loads the default camera registers.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection #(
	parameter int COORD_BITS = dtpr_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  dtpr_pkg::req_t                  req,
	output logic                            done,
	output dtpr_pkg::res_t                  res,
	input  logic                            cfg_we,
	input  logic [dtpr_pkg::IDX_BITS-1:0]   cfg_idx,
	input  logic [dtpr_pkg::CFG_BITS-1:0]   cfg_wdata
);

	localparam int CW = (COORD_BITS < dtpr_pkg::FIELD_BITS) ? COORD_BITS
		: dtpr_pkg::FIELD_BITS;
	localparam int NS = dtpr_pkg::DIV_STEPS;

	logic [dtpr_pkg::CFG_BITS-1:0] scale_q, c00_q, c01_q, c02_q, c10_q, c11_q, c12_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= dtpr_pkg::RST_DEPTH_SCALE;
			c00_q   <= dtpr_pkg::RST_INV_R0C0;
			c01_q   <= dtpr_pkg::RST_INV_R0C1;
			c02_q   <= dtpr_pkg::RST_INV_R0C2;
			c10_q   <= dtpr_pkg::RST_INV_R1C0;
			c11_q   <= dtpr_pkg::RST_INV_R1C1;
			c12_q   <= dtpr_pkg::RST_INV_R1C2;
		end else if (cfg_we) begin
			case (cfg_idx)
				dtpr_pkg::REG_DEPTH_SCALE: scale_q <= cfg_wdata;
				dtpr_pkg::REG_INV_R0C0:    c00_q   <= cfg_wdata;
				dtpr_pkg::REG_INV_R0C1:    c01_q   <= cfg_wdata;
				dtpr_pkg::REG_INV_R0C2:    c02_q   <= cfg_wdata;
				dtpr_pkg::REG_INV_R1C0:    c10_q   <= cfg_wdata;
				dtpr_pkg::REG_INV_R1C1:    c11_q   <= cfg_wdata;
				dtpr_pkg::REG_INV_R1C2:    c12_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	dtpr_pkg::div_t        chain [NS+1];
	logic [2*CW-1:0]       crd   [NS+1];

	// request enters the first cell
	always_comb begin
		chain[0].vld = start & ~busy;
		chain[0].nz  = |req.disparity_q4;
		chain[0].num = {scale_q, 4'b0000};
		chain[0].rem = '0;
		chain[0].den = req.disparity_q4;
		crd[0]       = {req.pixel_column[CW-1:0], req.pixel_row[CW-1:0]};
	end

	for (genvar i = 0; i < NS; i++) begin : g_cell
		dtpr_div_cell #(.CW(CW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.din     (chain[i]),
			.crd_in  (crd[i]),
			.dout    (chain[i+1]),
			.crd_out (crd[i+1])
		);
	end

	dtpr_post #(.CW(CW)) u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (chain[NS]),
		.crd    (crd[NS]),
		.c00    (c00_q),
		.c01    (c01_q),
		.c02    (c02_q),
		.c10    (c10_q),
		.c11    (c11_q),
		.c12    (c12_q),
		.done   (done),
		.res    (res)
	);

endmodule
